// ===== src/policy_rule_table_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the policy rule table
// Clocked property checks that compile away under synthesis.
// ---------------------------------------------------------------------------
`ifndef POLICY_RULE_TABLE_ASSERT_SVH
`define POLICY_RULE_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define PRT_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("policy_rule_table assertion failed");
`define PRT_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("policy_rule_table assertion failed");
`else
`define PRT_ASSERT(lbl, clk_s, rst_s, prop)
`define PRT_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif

`endif

// ===== src/prt_pkg.sv =====
// ---------------------------------------------------------------------------
// prt_pkg
// Types, codes and helpers shared by the policy rule table modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prt_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  src_len;
    logic [7:0]  dst_len;
    logic [7:0]  tos;
    logic [2:0]  action;
    logic [7:0]  route_table;
    logic [31:0] preference;
    logic [11:0] iface_index;
    logic [31:0] nat_map_addr;
    logic [3:0]  given_mask;
  } prt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_table;
    logic        is_nat;
    logic [31:0] out_map_addr;
    logic [5:0]  out_src_len;
    logic        last;
  } prt_out_t;

  typedef struct packed {
    logic [31:0] pref;
    logic [7:0]  tbl;
    logic [2:0]  act;
    logic [31:0] src;
    logic [5:0]  src_len;
    logic [31:0] dst;
    logic [5:0]  dst_len;
    logic [7:0]  tos;
    logic [11:0] iface;
    logic [31:0] map;
  } prt_rule_t;

  typedef struct packed {
    logic lk_hit;
    logic del_hit;
  } prt_match_t;

  localparam int RULE_W = $bits(prt_rule_t);

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  localparam logic [2:0] ACT_ANY      = 3'd0;
  localparam logic [2:0] ACT_UNICAST  = 3'd1;
  localparam logic [2:0] ACT_NAT      = 3'd2;
  localparam logic [2:0] ACT_UNREACH  = 3'd3;
  localparam logic [2:0] ACT_PROHIBIT = 3'd5;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_INVALID   = 3'd1;
  localparam logic [2:0] STS_NOTFOUND  = 3'd2;
  localparam logic [2:0] STS_FULL      = 3'd3;
  localparam logic [2:0] STS_UNREACH   = 3'd4;
  localparam logic [2:0] STS_BLACKHOLE = 3'd5;
  localparam logic [2:0] STS_PROHIBIT  = 3'd6;

  localparam logic [31:0] PREF_MAIN    = 32'h0000_7FFE;
  localparam logic [31:0] PREF_DEFAULT = 32'h0000_7FFF;
  localparam logic [7:0]  MAX_PREFIX   = 8'd32;
  localparam logic [7:0]  TOS_ALLOWED  = 8'h1E;

  localparam logic [1:0] REG_TOS_EN = 2'd0;

  // length 0 shifts by 32 and gives an all-zero mask
  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [5:0] sh;
    sh = 6'd32 - len;
    return 32'hFFFF_FFFF << sh;
  endfunction

  function automatic prt_rule_t builtin_rule(input logic [1:0] slot);
    prt_rule_t r;
    r     = '0;
    r.act = ACT_UNICAST;
    case (slot)
      2'd0: begin
        r.pref = 32'd0;
        r.tbl  = 8'd255;
      end
      2'd1: begin
        r.pref = PREF_MAIN;
        r.tbl  = 8'd254;
      end
      default: begin
        r.pref = PREF_DEFAULT;
        r.tbl  = 8'd253;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/prt_ram.sv =====
// ---------------------------------------------------------------------------
// prt_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/prt_match.sv =====
// ---------------------------------------------------------------------------
// prt_match
// Compares one stored rule against the current request for lookup and delete.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prt_match (
  input  wire prt_pkg::prt_in_t   req,
  input  wire prt_pkg::prt_rule_t rule,
  input  wire logic               tos_en,
  output prt_pkg::prt_match_t     hit
);

  logic src_ok, dst_ok, tos_ok, ifc_ok;

  always_comb begin
    src_ok = ((req.src_addr ^ rule.src) & prt_pkg::prefix_mask(rule.src_len)) == 32'd0;
    dst_ok = ((req.dst_addr ^ rule.dst) & prt_pkg::prefix_mask(rule.dst_len)) == 32'd0;
    tos_ok = !(tos_en && rule.tos != 8'd0 && rule.tos != req.tos);
    ifc_ok = !(rule.iface != 12'd0 && rule.iface != req.iface_index);
    hit.lk_hit = src_ok && dst_ok && tos_ok && ifc_ok;

    hit.del_hit = (!req.given_mask[0] || req.src_addr == rule.src)
               && (req.src_len == {2'b00, rule.src_len})
               && (req.dst_len == {2'b00, rule.dst_len})
               && (!req.given_mask[1] || req.dst_addr == rule.dst)
               && (req.tos == rule.tos)
               && (req.action == prt_pkg::ACT_ANY || req.action == rule.act)
               && (!req.given_mask[2] || req.preference == rule.pref)
               && (!req.given_mask[3] || req.iface_index == rule.iface)
               && (req.route_table == 8'd0 || req.route_table == rule.tbl);
  end

endmodule

`default_nettype wire

// ===== src/policy_rule_table.sv =====
// Lookup: walks the stored rules in order, one RAM read each; one word per unicast or NAT match.
// Insert: one RAM read per rule scanned, a RAM read and write per rule moved up,
//   plus a read of the second rule with an automatic preference; delete likewise.
// One request at a time; the rule RAM's single read port sets the pace.
// Reset: synchronous; the INIT state then writes the three built-in rules into the RAM,
//   during which no request is taken. TOS matching resets to enabled.
`timescale 1ns / 1ps
`default_nettype none

`include "policy_rule_table_assert.svh"

module policy_rule_table #(
  parameter int RULE_SLOTS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire prt_pkg::prt_in_t  in_word,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output prt_pkg::prt_out_t      out_word,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int IW = $clog2(RULE_SLOTS);
  localparam int CW = $clog2(RULE_SLOTS + 1);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CHK    = 4'd2;
  localparam logic [3:0] S_PRE_RD = 4'd3;
  localparam logic [3:0] S_PRE_EV = 4'd4;
  localparam logic [3:0] S_LK_RD  = 4'd5;
  localparam logic [3:0] S_LK_EV  = 4'd6;
  localparam logic [3:0] S_INS_RD = 4'd7;
  localparam logic [3:0] S_INS_EV = 4'd8;
  localparam logic [3:0] S_DEL_RD = 4'd9;
  localparam logic [3:0] S_DEL_EV = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0]         state, state_next;
  logic [IW-1:0]      idx, idx_next;
  logic [CW-1:0]      cnt, cnt_next;
  prt_pkg::prt_in_t   req, req_next;
  logic [31:0]        pref_w, pref_w_next;
  prt_pkg::prt_rule_t carry, carry_next;
  logic               found, found_next;
  logic [2:0]         fin_status, fin_status_next;
  logic               out_valid_next;
  prt_pkg::prt_out_t  out_word_next;
  logic               tos_en;

  logic               wr_en;
  logic [IW-1:0]      wr_addr, rd_addr;
  prt_pkg::prt_rule_t wr_data, rd_data, new_rule;
  prt_pkg::prt_match_t hit;
  logic               out_free;
  logic [CW:0]        idx_ext;

  prt_ram #(
    .WIDTH(prt_pkg::RULE_W),
    .DEPTH(RULE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  prt_match u_match (
    .req    (req),
    .rule   (rd_data),
    .tos_en (tos_en),
    .hit    (hit)
  );

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = 32'd0;
    if (paddr[2:1] == prt_pkg::REG_TOS_EN && paddr[1:0] == 2'b00) begin
      prdata = {31'd0, tos_en};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tos_en <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      tos_en <= pwdata[0];
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign idx_ext  = (CW + 1)'(idx);

  // during a delete shift the read runs one slot ahead of the write
  assign rd_addr = ((state == S_DEL_RD || state == S_DEL_EV) && found) ? idx + IW'(1) : idx;

  always_comb begin
    new_rule         = '0;
    new_rule.pref    = pref_w;
    new_rule.tbl     = req.route_table;
    new_rule.act     = req.action;
    new_rule.src     = req.src_addr;
    new_rule.src_len = req.src_len[5:0];
    new_rule.dst     = req.dst_addr;
    new_rule.dst_len = req.dst_len[5:0];
    new_rule.tos     = req.tos;
    new_rule.iface   = req.iface_index;
    new_rule.map     = req.nat_map_addr;
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    cnt_next        = cnt;
    req_next        = req;
    pref_w_next     = pref_w;
    carry_next      = carry;
    found_next      = found;
    fin_status_next = fin_status;
    out_valid_next  = out_valid && !out_ready;
    out_word_next   = out_word;
    wr_en           = 1'b0;
    wr_addr         = idx;
    wr_data         = rd_data;

    case (state)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_data = prt_pkg::builtin_rule(idx[1:0]);
        idx_next = idx + IW'(1);
        if (idx == IW'(2)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_next   = in_word;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        idx_next   = '0;
        found_next = 1'b0;
        case (req.req_type)
          prt_pkg::REQ_LOOKUP: begin
            if (cnt == '0) begin
              fin_status_next = prt_pkg::STS_UNREACH;
              state_next      = S_FIN;
            end else begin
              state_next = S_LK_RD;
            end
          end
          prt_pkg::REQ_INSERT: begin
            pref_w_next = req.preference;
            if (req.src_len > prt_pkg::MAX_PREFIX || req.dst_len > prt_pkg::MAX_PREFIX
                || (req.tos & ~prt_pkg::TOS_ALLOWED) != 8'd0) begin
              fin_status_next = prt_pkg::STS_INVALID;
              state_next      = S_FIN;
            end else if (cnt == CW'(RULE_SLOTS)) begin
              fin_status_next = prt_pkg::STS_FULL;
              state_next      = S_FIN;
            end else if (req.preference == 32'd0 && cnt >= CW'(2)) begin
              idx_next   = IW'(1);
              state_next = S_PRE_RD;
            end else begin
              state_next = S_INS_RD;
            end
          end
          prt_pkg::REQ_DELETE: begin
            if (cnt == '0) begin
              fin_status_next = prt_pkg::STS_NOTFOUND;
              state_next      = S_FIN;
            end else begin
              state_next = S_DEL_RD;
            end
          end
          default: begin
            fin_status_next = prt_pkg::STS_INVALID;
            state_next      = S_FIN;
          end
        endcase
      end
      S_PRE_RD: begin
        state_next = S_PRE_EV;
      end
      S_PRE_EV: begin
        // automatic preference: one below the second rule's, if nonzero, placed after the first
        if (rd_data.pref != 32'd0) begin
          pref_w_next = rd_data.pref - 32'd1;
        end
        state_next = S_INS_RD;
      end
      S_LK_RD: begin
        state_next = S_LK_EV;
      end
      S_LK_EV: begin
        if (hit.lk_hit) begin
          case (rd_data.act)
            prt_pkg::ACT_UNICAST, prt_pkg::ACT_NAT: begin
              if (out_free) begin
                out_valid_next         = 1'b1;
                out_word_next          = '0;
                out_word_next.status   = prt_pkg::STS_OK;
                out_word_next.out_table = rd_data.tbl;
                if (rd_data.act == prt_pkg::ACT_NAT) begin
                  out_word_next.is_nat       = 1'b1;
                  out_word_next.out_map_addr = rd_data.map;
                  out_word_next.out_src_len  = rd_data.src_len;
                end
                if (idx_ext + (CW + 1)'(1) == (CW + 1)'(cnt)) begin
                  fin_status_next = prt_pkg::STS_UNREACH;
                  state_next      = S_FIN;
                end else begin
                  idx_next   = idx + IW'(1);
                  state_next = S_LK_RD;
                end
              end
            end
            prt_pkg::ACT_UNREACH: begin
              fin_status_next = prt_pkg::STS_UNREACH;
              state_next      = S_FIN;
            end
            prt_pkg::ACT_PROHIBIT: begin
              fin_status_next = prt_pkg::STS_PROHIBIT;
              state_next      = S_FIN;
            end
            default: begin
              fin_status_next = prt_pkg::STS_BLACKHOLE;
              state_next      = S_FIN;
            end
          endcase
        end else if (idx_ext + (CW + 1)'(1) == (CW + 1)'(cnt)) begin
          fin_status_next = prt_pkg::STS_UNREACH;
          state_next      = S_FIN;
        end else begin
          idx_next   = idx + IW'(1);
          state_next = S_LK_RD;
        end
      end
      S_INS_RD: begin
        state_next = S_INS_EV;
      end
      S_INS_EV: begin
        // scan to the slot, then ripple the tail up one slot per step
        if (!found && idx_ext < (CW + 1)'(cnt) && rd_data.pref <= pref_w) begin
          idx_next   = idx + IW'(1);
          state_next = S_INS_RD;
        end else begin
          wr_en      = 1'b1;
          wr_data    = found ? carry : new_rule;
          carry_next = rd_data;
          found_next = 1'b1;
          if (idx_ext == (CW + 1)'(cnt)) begin
            cnt_next        = cnt + CW'(1);
            fin_status_next = prt_pkg::STS_OK;
            state_next      = S_FIN;
          end else begin
            idx_next   = idx + IW'(1);
            state_next = S_INS_RD;
          end
        end
      end
      S_DEL_RD: begin
        state_next = S_DEL_EV;
      end
      S_DEL_EV: begin
        if (!found) begin
          if (hit.del_hit) begin
            found_next = 1'b1;
            if (idx_ext + (CW + 1)'(1) == (CW + 1)'(cnt)) begin
              cnt_next        = cnt - CW'(1);
              fin_status_next = prt_pkg::STS_OK;
              state_next      = S_FIN;
            end else begin
              state_next = S_DEL_RD;
            end
          end else if (idx_ext + (CW + 1)'(1) == (CW + 1)'(cnt)) begin
            fin_status_next = prt_pkg::STS_NOTFOUND;
            state_next      = S_FIN;
          end else begin
            idx_next   = idx + IW'(1);
            state_next = S_DEL_RD;
          end
        end else begin
          wr_en   = 1'b1;
          wr_data = rd_data;
          if (idx_ext + (CW + 1)'(2) == (CW + 1)'(cnt)) begin
            cnt_next        = cnt - CW'(1);
            fin_status_next = prt_pkg::STS_OK;
            state_next      = S_FIN;
          end else begin
            idx_next   = idx + IW'(1);
            state_next = S_DEL_RD;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_next       = 1'b1;
          out_word_next        = '0;
          out_word_next.status = fin_status;
          out_word_next.last   = 1'b1;
          state_next           = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      idx       <= '0;
      cnt       <= CW'(3);
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      cnt       <= cnt_next;
      found     <= found_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req        <= req_next;
    pref_w     <= pref_w_next;
    carry      <= carry_next;
    fin_status <= fin_status_next;
    out_word   <= out_word_next;
  end

  `PRT_ASSERT(a_cnt_bound, clk, rst, cnt <= CW'(RULE_SLOTS))
  `PRT_ASSERT(a_wr_states, clk, rst, wr_en |-> (state == S_INIT || state == S_INS_EV || state == S_DEL_EV))
  `PRT_ASSERT(a_one_at_time, clk, rst, (in_valid && in_ready) |=> !in_ready)
  `PRT_ASSERT(a_cnt_stable_idle, clk, rst, (state == S_IDLE && $past(state) == S_IDLE) |-> $stable(cnt))

endmodule

`default_nettype wire
